[src/csim_pkg.sv]
// Shared types and constants for the cosine similarity engine.
// No dependencies; every other file imports this package.
package csim_pkg;

    localparam int ELEM_W = 16;     // Q1.15 element width
    localparam int SIM_W  = 16;     // Q1.15 result width
    localparam int FRAC_W = 15;     // fraction bits of the result
    localparam int PROD_W = 2 * ELEM_W;

    localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sh7FFF;
    localparam logic signed [SIM_W-1:0] SIM_MIN = 16'sh8000;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SQRT,
        S_DIV,
        S_FIN
    } t_back_state;

endpackage

[src/csim_if.sv]
// Handshake channels of the cosine similarity engine: input and result words.
// Depends on csim_pkg.
interface csim_in_if;
    import csim_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     is_last;

    modport source (output valid, elem_a, elem_b, is_last, input ready);
    modport sink   (input valid, elem_a, elem_b, is_last, output ready);
endinterface

interface csim_out_if;
    import csim_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SIM_W-1:0] similarity;
    logic                    too_long;

    modport source (output valid, similarity, too_long, input ready);
    modport sink   (input valid, similarity, too_long, output ready);
endinterface

[src/cosine_similarity_engine_core.sv]
// Cosine similarity engine, top level: front accumulator, job queue, back end.
// Depends on csim_pkg, csim_if, csim_front, csim_fifo and csim_back.
//
// The block takes one pair of signed Q1.15 elements per word on i_in and
// accumulates the dot product and both squared norms exactly. The word with
// is_last set closes the vector and yields one result word on o_out:
// trunc(dot * 2^15 / floor(sqrt(norm_a * norm_b))), saturated to the Q1.15
// range, or 0 when either norm is zero. More than MAX_LEN pairs in a vector
// give similarity 0 with too_long set; the surplus pairs are not summed.
// Words that are not last never produce a result. The front takes one word
// per cycle while the job queue has room; each word passes the product
// register and then the accumulator. Each closed vector queues a job for
// the back end, which works one job at a time: it takes the job, runs a
// shift-add multiply of the norms, a bit-pair square root and a restoring
// divide, then loads the result register. A run of closed vectors that come
// faster than the back end finishes them stalls i_in once the two-entry job
// queue fills. The result register holds a word until taken while the back
// end goes on with the next job.
module cosine_similarity_engine_core #(
    parameter int MAX_LEN = 4096       // 1 .. 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csim_in_if.sink    i_in,
    csim_out_if.source o_out
);
    import csim_pkg::*;

    // Accumulator width: |sum| <= MAX_LEN * 2^30, plus sign
    localparam int ACC_W = $clog2(MAX_LEN) + 32;
    // Pair count saturates at MAX_LEN + 1
    localparam int CNT_W = $clog2(MAX_LEN + 2);
    localparam int JOB_W = 3 * ACC_W + 1;

    logic             fr_job_vld;
    logic             fr_job_rdy;
    logic [JOB_W-1:0] fr_job_data;
    logic             bk_job_vld;
    logic             bk_job_rdy;
    logic [JOB_W-1:0] bk_job_data;

    // Accumulate; push one job per closed vector
    csim_front #(
        .MAX_LEN (MAX_LEN),
        .ACC_W   (ACC_W),
        .CNT_W   (CNT_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_job_vld  (fr_job_vld),
        .i_job_rdy  (fr_job_rdy),
        .o_job_data (fr_job_data)
    );

    // Hold up to two closed vectors while the back end is busy
    csim_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (fr_job_vld),
        .o_push_rdy  (fr_job_rdy),
        .i_push_data (fr_job_data),
        .o_pop_vld   (bk_job_vld),
        .i_pop_rdy   (bk_job_rdy),
        .o_pop_data  (bk_job_data)
    );

    // Multiply the norms, root, divide and saturate; drive the result word
    csim_back #(
        .ACC_W (ACC_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_vld  (bk_job_vld),
        .o_job_rdy  (bk_job_rdy),
        .i_job_data (bk_job_data),
        .o_out      (o_out)
    );

endmodule

[src/csim_fifo.sv]
// Short register queue that parts the accumulate front from the divide back.
// Depends on csim_pkg (no items used beyond the house import).
module csim_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2        // power of two, at least 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_vld,
    output logic             o_push_rdy,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_vld,
    input  logic             i_pop_rdy,
    output logic [WIDTH-1:0] o_pop_data
);
    import csim_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             push;
    logic             pop;

    assign o_push_rdy = (r_count != CW'(DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[src/csim_front.sv]
// Front end: takes element pairs, registers the three products, accumulates
// them and queues one job per vector. Depends on csim_pkg and csim_if.
module csim_front #(
    parameter int MAX_LEN = 4096,
    parameter int ACC_W   = 44,
    parameter int CNT_W   = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csim_in_if.sink            i_in,
    output logic               o_job_vld,
    input  logic               i_job_rdy,
    output logic [3*ACC_W:0]   o_job_data
);
    import csim_pkg::*;

    // product stage
    logic                     r_s1_vld;
    logic                     r_s1_last;
    logic signed [PROD_W-1:0] r_s1_ab;
    logic [PROD_W-2:0]        r_s1_aa;
    logic [PROD_W-2:0]        r_s1_bb;

    logic signed [PROD_W-1:0] p_ab;
    logic signed [PROD_W-1:0] p_aa;
    logic signed [PROD_W-1:0] p_bb;

    // accumulators
    logic signed [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0]        r_na;
    logic [ACC_W-1:0]        r_nb;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [ACC_W-1:0] n_dot;
    logic [ACC_W-1:0]        n_na;
    logic [ACC_W-1:0]        n_nb;
    logic [CNT_W-1:0]        n_cnt;

    logic s1_drain;
    logic in_take;
    logic too_long;

    assign p_ab = i_in.elem_a * i_in.elem_b;
    assign p_aa = i_in.elem_a * i_in.elem_a;
    assign p_bb = i_in.elem_b * i_in.elem_b;

    // hold a last word in the product stage until the queue has room
    assign s1_drain   = r_s1_vld && (!r_s1_last || i_job_rdy);
    assign i_in.ready = !r_s1_vld || s1_drain;
    assign in_take    = i_in.valid && i_in.ready;
    assign o_job_vld  = r_s1_vld && r_s1_last;

    always_comb begin
        if (r_cnt < CNT_W'(MAX_LEN)) begin
            n_dot = r_dot + {{(ACC_W-PROD_W){r_s1_ab[PROD_W-1]}}, r_s1_ab};
            n_na  = r_na + {{(ACC_W-PROD_W+1){1'b0}}, r_s1_aa};
            n_nb  = r_nb + {{(ACC_W-PROD_W+1){1'b0}}, r_s1_bb};
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_dot = r_dot;
            n_na  = r_na;
            n_nb  = r_nb;
            n_cnt = CNT_W'(MAX_LEN + 1);
        end
    end

    assign too_long   = (n_cnt > CNT_W'(MAX_LEN));
    assign o_job_data = {too_long, n_dot, n_na, n_nb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_last <= i_in.is_last;
            r_s1_ab   <= p_ab;
            r_s1_aa   <= p_aa[PROD_W-2:0];
            r_s1_bb   <= p_bb[PROD_W-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
            r_cnt <= '0;
        end else if (s1_drain) begin
            if (r_s1_last) begin
                // vector done: clear for the next one
                r_dot <= '0;
                r_na  <= '0;
                r_nb  <= '0;
                r_cnt <= '0;
            end else begin
                r_dot <= n_dot;
                r_na  <= n_na;
                r_nb  <= n_nb;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

[src/csim_back.sv]
// Back end: per job, shift-add multiply of the norms, bit-pair square root,
// restoring divide and saturation into the result register. Depends on csim_pkg.
module csim_back #(
    parameter int ACC_W = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_vld,
    output logic             o_job_rdy,
    input  logic [3*ACC_W:0] i_job_data,
    csim_out_if.source       o_out
);
    import csim_pkg::*;

    localparam int STEP_W = $clog2(ACC_W + 1);

    t_back_state r_state;
    t_back_state n_state;

    logic [STEP_W-1:0]       r_step;
    logic [2*ACC_W-1:0]      r_prod;
    logic [ACC_W-1:0]        r_mc;
    logic [ACC_W+1:0]        r_rem;
    logic [ACC_W-1:0]        r_root;
    logic [ACC_W-1:0]        r_drem;
    logic [SIM_W-1:0]        r_dlow;
    logic [SIM_W-1:0]        r_q;
    logic [ACC_W-1:0]        r_dmag;
    logic                    r_neg;
    logic                    r_zero;
    logic                    r_tl;

    logic                    r_out_vld;
    logic signed [SIM_W-1:0] r_out_sim;
    logic                    r_out_tl;

    // job fields
    logic                    j_tl;
    logic signed [ACC_W-1:0] j_dot;
    logic [ACC_W-1:0]        j_na;
    logic [ACC_W-1:0]        j_nb;

    // datapath terms
    logic [ACC_W:0]          mul_sum;
    logic [ACC_W+3:0]        sq_sh;
    logic [ACC_W+3:0]        sq_trial;
    logic                    sq_ge;
    logic [ACC_W:0]          dv_sh;
    logic                    dv_ge;
    logic signed [SIM_W-1:0] sat_sim;
    logic                    out_free;
    logic                    step_end;

    assign {j_tl, j_dot, j_na, j_nb} = i_job_data;

    assign mul_sum  = {1'b0, r_prod[2*ACC_W-1:ACC_W]} + (r_prod[0] ? {1'b0, r_mc} : '0);
    assign sq_sh    = {r_rem, r_prod[2*ACC_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign dv_sh    = {r_drem, r_dlow[SIM_W-1]};
    assign dv_ge    = (dv_sh >= {1'b0, r_root});

    always_comb begin
        if (r_zero) begin
            sat_sim = '0;
        end else if (r_neg) begin
            sat_sim = (r_q > SIM_W'(2**FRAC_W)) ? SIM_MIN : -$signed(r_q);
        end else begin
            sat_sim = (r_q > SIM_W'(2**FRAC_W - 1)) ? SIM_MAX : $signed(r_q);
        end
    end

    assign out_free = !r_out_vld || o_out.ready;

    always_comb begin
        n_state   = r_state;
        o_job_rdy = 1'b0;
        step_end  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_job_rdy = 1'b1;
                if (i_job_vld) begin
                    if (j_tl || j_na == '0 || j_nb == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                step_end = (r_step == STEP_W'(ACC_W - 1));
                if (step_end) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                step_end = (r_step == STEP_W'(ACC_W - 1));
                if (step_end) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                step_end = (r_step == STEP_W'(SIM_W - 1));
                if (step_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == S_IDLE || step_end) begin
            r_step <= '0;
        end else begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_job_vld) begin
                    r_tl   <= j_tl;
                    r_zero <= j_tl || j_na == '0 || j_nb == '0;
                    r_neg  <= j_dot[ACC_W-1];
                    r_dmag <= j_dot[ACC_W-1] ? ACC_W'(-j_dot) : ACC_W'(j_dot);
                    r_prod <= {{ACC_W{1'b0}}, j_na};
                    r_mc   <= j_nb;
                end
            end
            S_MUL: begin
                r_prod <= {mul_sum, r_prod[ACC_W-1:1]};
                if (step_end) begin
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            S_SQRT: begin
                // consume two product bits per step, MSB first
                r_prod <= {r_prod[2*ACC_W-3:0], 2'b00};
                r_rem  <= sq_ge ? (ACC_W+2)'(sq_sh - sq_trial) : sq_sh[ACC_W+1:0];
                r_root <= {r_root[ACC_W-2:0], sq_ge};
                if (step_end) begin
                    r_drem <= {1'b0, r_dmag[ACC_W-1:1]};
                    r_dlow <= {r_dmag[0], {(SIM_W-1){1'b0}}};
                    r_q    <= '0;
                end
            end
            S_DIV: begin
                r_drem <= dv_ge ? ACC_W'(dv_sh - {1'b0, r_root}) : dv_sh[ACC_W-1:0];
                r_dlow <= {r_dlow[SIM_W-2:0], 1'b0};
                r_q    <= {r_q[SIM_W-2:0], dv_ge};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_sim <= sat_sim;
            r_out_tl  <= r_tl;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.similarity = r_out_sim;
    assign o_out.too_long   = r_out_tl;

endmodule

[tb/cosine_similarity_engine_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for cosine_similarity_engine_core: streams element pairs on i_in and checks result words.
// Depends on csim_pkg, csim_if and the RTL; it holds its own fixed-point model of the engine.
module cosine_similarity_engine_core_tb;
    import csim_pkg::*;

    localparam int MAX_LEN      = 4096;
    localparam int ACC_W        = 44;
    // back-end job time plus front latency and some slack
    localparam int DRAIN_CYCLES = 2 * ACC_W + 18 + 20;
    localparam int RANDOM_ITEMS = 900;
    localparam int SHOWN_ERRORS = 10;

    localparam logic signed [ELEM_W-1:0] EL_MAX = 16'sh7FFF;
    localparam logic signed [ELEM_W-1:0] EL_MIN = 16'sh8000;
    localparam logic [63:0] NEG_LIMIT = 64'd1 << FRAC_W;

    // per phase: sender idle percent, receiver idle percent
    localparam int SRC_IDLE [3] = '{9, 48, 0};
    localparam int SNK_IDLE [3] = '{48, 9, 0};

    // long vectors: exactly full, one pair over, several over
    localparam int LONG_LENS [3] = '{MAX_LEN, MAX_LEN + 1, MAX_LEN + 6};

    typedef struct packed {
        logic signed [SIM_W-1:0] sim;
        logic                    too_long;
    } sim_word_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic                     last;
        logic                     known;    // expected word typed in below
        logic signed [SIM_W-1:0]  sim;
        logic                     too_long;
    } stim_row_t;

    typedef enum int {
        VK_RANDOM,
        VK_EXTREME,
        VK_ZERO,
        VK_SAME,
        VK_OPPOSITE,
        VK_SMALL
    } vec_kind_t;

    localparam sim_word_t TOO_LONG_WORD = '{sim: '0, too_long: 1'b1};

    // Directed pairs. Rows with known=0 are checked against the model.
    localparam stim_row_t DIRECTED_ROWS [22] = '{
        // parallel extremes: the quotient reaches +1.0 and saturates
        '{EL_MAX, EL_MAX, 1'b1, 1'b1, SIM_MAX, 1'b0},
        '{EL_MIN, EL_MIN, 1'b1, 1'b1, SIM_MAX, 1'b0},
        // antiparallel extremes: exactly -1.0; then unit elements, parallel and antiparallel
        '{EL_MIN, EL_MAX, 1'b1, 1'b1, SIM_MIN, 1'b0},
        '{EL_MAX, EL_MIN, 1'b1, 1'b1, SIM_MIN, 1'b0},
        '{16'sd1, 16'sd1, 1'b1, 1'b1, SIM_MAX, 1'b0},
        '{-16'sd1, 16'sd1, 1'b1, 1'b1, SIM_MIN, 1'b0},
        // zero norm on one side or both
        '{16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 1'b0},
        '{16'sd0, EL_MIN, 1'b1, 1'b1, 16'sd0, 1'b0},
        '{EL_MAX, 16'sd0, 1'b1, 1'b1, 16'sd0, 1'b0},
        // orthogonal vectors
        '{16'sd1, 16'sd0, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd1, 1'b1, 1'b1, 16'sd0, 1'b0},
        '{16'sd3, 16'sd4, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd4, -16'sd3, 1'b1, 1'b1, 16'sd0, 1'b0},
        // mixed multi-pair vectors
        '{16'sh4000, 16'sh2000, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{-16'sh1234, 16'sh0F0F, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh00FF, -16'sh7F00, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sh5555, 16'shAAAA, 1'b1, 1'b0, 16'sd0, 1'b0},
        '{16'sd100, 16'sd200, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd300, -16'sd50, 1'b0, 1'b0, 16'sd0, 1'b0},
        '{16'sd7, 16'sd7, 1'b1, 1'b0, 16'sd0, 1'b0},
        // very unequal magnitudes
        '{EL_MIN, 16'sd1, 1'b1, 1'b1, SIM_MIN, 1'b0},
        '{16'sd1, 16'sd2, 1'b1, 1'b1, SIM_MAX, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    csim_in_if  in_if ();
    csim_out_if out_if ();

    cosine_similarity_engine_core #(
        .MAX_LEN (MAX_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_cnt = 0;

    // model state
    longint          dot_acc;
    longint unsigned sqa_acc;
    longint unsigned sqb_acc;
    int unsigned     pair_cnt;

    sim_word_t pending_sims [$];

    function automatic void clear_sums();
        dot_acc  = 0;
        sqa_acc  = 0;
        sqb_acc  = 0;
        pair_cnt = 0;
    endfunction

    // floor(sqrt(x*y)), bit by bit from the top
    function automatic logic [47:0] root_of_product(longint unsigned x, longint unsigned y);
        logic [95:0] prod;
        logic [95:0] trial_sq;
        logic [47:0] root;
        logic [47:0] trial;
        prod = 96'(x) * 96'(y);
        root = '0;
        for (int bit_i = 47; bit_i >= 0; bit_i--) begin
            trial    = root | (48'd1 << bit_i);
            trial_sq = 96'(trial) * 96'(trial);
            if (trial_sq <= prod) root = trial;
        end
        return root;
    endfunction

    // Fold one pair into the sums; return 1 with the similarity word on the last pair.
    function automatic bit predict_similarity(input logic signed [ELEM_W-1:0] a,
                                              input logic signed [ELEM_W-1:0] b,
                                              input logic last, output sim_word_t word);
        longint      pa;
        longint      pb;
        logic [63:0] mag;
        logic [63:0] quot;
        logic [47:0] den;
        word = '{sim: '0, too_long: 1'b0};
        pa   = a;
        pb   = b;
        if (pair_cnt < MAX_LEN) begin
            dot_acc  += pa * pb;
            sqa_acc  += pa * pa;
            sqb_acc  += pb * pb;
            pair_cnt++;
        end else begin
            pair_cnt = MAX_LEN + 1;
        end
        if (!last) return 1'b0;
        if (pair_cnt > MAX_LEN) begin
            word.too_long = 1'b1;
        end else if (sqa_acc != 0 && sqb_acc != 0) begin
            den  = root_of_product(sqa_acc, sqb_acc);
            mag  = (dot_acc < 0) ? 64'(-dot_acc) : 64'(dot_acc);
            quot = (mag << FRAC_W) / 64'(den);
            if (dot_acc < 0)
                word.sim = (quot > NEG_LIMIT) ? SIM_MIN : SIM_W'(-quot);
            else
                word.sim = (quot > 64'(SIM_MAX)) ? SIM_MAX : SIM_W'(quot);
        end
        clear_sums();
        return 1'b1;
    endfunction

    // Present one word from a falling edge, hold it until taken, return at the next falling edge.
    task automatic drive_pair(input logic signed [ELEM_W-1:0] a,
                              input logic signed [ELEM_W-1:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.elem_a  <= a;
        in_if.elem_b  <= b;
        in_if.is_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Send a pair; once it is taken, queue the word it closes (typed-in or modeled).
    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b, input logic last,
                             input bit use_known, input sim_word_t known_word);
        sim_word_t modeled;
        drive_pair(a, b, last);
        if (predict_similarity(a, b, last, modeled))
            pending_sims.push_back(use_known ? known_word : modeled);
    endtask

    function automatic logic signed [ELEM_W-1:0] extreme_elem();
        case ($urandom_range(4))
            0:       return EL_MAX;
            1:       return EL_MIN;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    task automatic send_vector(input int len, input vec_kind_t kind);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        bit                       zero_a;
        zero_a = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (kind)
                VK_EXTREME: begin
                    a = extreme_elem();
                    b = extreme_elem();
                end
                VK_ZERO: begin
                    if (zero_a) a = '0;
                    else b = '0;
                end
                VK_SAME:     b = a;
                VK_OPPOSITE: b = -a;
                VK_SMALL: begin
                    a = a >>> 12;
                    b = b >>> 12;
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1, 1'b0, '0);
        end
    endtask

    // Receiver: drop ready at random per the current phase.
    always @(negedge i_clk) begin
        out_if.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare every taken result word with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        sim_word_t got;
        sim_word_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{sim: out_if.similarity, too_long: out_if.too_long};
            if (pending_sims.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOWN_ERRORS)
                    $display("unexpected word: similarity=%0d too_long=%b",
                             got.sim, got.too_long);
            end else begin
                want = pending_sims.pop_front();
                if (got.sim !== want.sim || got.too_long !== want.too_long) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOWN_ERRORS)
                        $display("mismatch: expected similarity=%0d too_long=%b, got %0d %b",
                                 want.sim, want.too_long, got.sim, got.too_long);
                end
            end
        end
    end

    initial begin
        int        sent;
        int        vlen;
        stim_row_t row;
        in_if.valid   = 1'b0;
        in_if.elem_a  = '0;
        in_if.elem_b  = '0;
        in_if.is_last = 1'b0;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;
        src_idle_pct  = SRC_IDLE[0];
        snk_idle_pct  = SNK_IDLE[0];
        clear_sums();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            send_pair(row.a, row.b, row.last, row.known,
                      '{sim: row.sim, too_long: row.too_long});
        end

        // Full-length vector fills the sums to the top; longer ones must flag too_long.
        foreach (LONG_LENS[k]) begin
            for (int i = 0; i < LONG_LENS[k]; i++)
                send_pair(EL_MIN, ($urandom_range(7) == 0) ? EL_MAX : EL_MIN,
                          i == LONG_LENS[k] - 1, LONG_LENS[k] > MAX_LEN, TOO_LONG_WORD);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = SRC_IDLE[phase];
            snk_idle_pct = SNK_IDLE[phase];
            sent = 0;
            while (sent < RANDOM_ITEMS / 3) begin
                // mostly short vectors, so the back end queue fills and stalls i_in
                vlen = ($urandom_range(19) == 0) ? $urandom_range(17, 120)
                                                 : $urandom_range(1, 16);
                send_vector(vlen, vec_kind_t'($urandom_range(VK_SMALL)));
                sent += vlen;
            end
        end
        in_if.valid <= 1'b0;

        while (pending_sims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_sims.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
